// ===== rtl/dpsm_pkg.sv =====
// Shared types and constants of the demand-paging swap manager.
// Holds the command/status structs between controller and datapath.
// No dependencies.
package dpsm_pkg;

   // widths of the command/status fields at the largest legal configuration
   localparam int PA_MAX_W  = 10;
   localparam int BA_MAX_W  = 14;
   localparam int FR_MAX_W  = 7;
   localparam int PID_MAX_W = 4;
   localparam int DI_MAX_W  = 6;

   localparam logic [1:0] KIND_MAP   = 2'd0;
   localparam logic [1:0] KIND_STORE = 2'd1;
   localparam logic [1:0] KIND_LOAD  = 2'd2;

   localparam logic [1:0] STAT_DONE         = 2'd0;
   localparam logic [1:0] STAT_NOT_WRITABLE = 2'd1;
   localparam logic [1:0] STAT_NO_OWNER     = 2'd2;

   localparam logic [7:0] MARK_PRESENT = 8'd1;
   localparam logic [7:0] MARK_DISC    = 8'd2;
   localparam logic [7:0] NONE_BYTE    = 8'd255;

   localparam logic [1:0] BYTE_PERM  = 2'd0;
   localparam logic [1:0] BYTE_FRAME = 2'd1;
   localparam logic [1:0] BYTE_MARK  = 2'd2;
   localparam logic [1:0] BYTE_DISC  = 2'd3;

   typedef struct packed {
      logic [PID_MAX_W-1:0] pid_sel;
      logic                 pm_re;
      logic                 pm_we;
      logic [PA_MAX_W-1:0]  pm_addr;
      logic [7:0]           pm_wdata;
      logic                 bs_re;
      logic                 bs_we;
      logic [BA_MAX_W-1:0]  bs_addr;
      logic [7:0]           bs_wdata;
      logic                 tbl_load;
      logic                 tbl_evict;
      logic                 frame_we;
      logic                 frame_free;
      logic [FR_MAX_W-1:0]  frame_idx;
      logic                 victim_adv;
      logic                 disc_we;
      logic                 disc_free;
      logic [DI_MAX_W-1:0]  disc_idx;
   } dpsm_cmd_type;

   typedef struct packed {
      logic                 frame_found;
      logic [FR_MAX_W-1:0]  free_frame;
      logic [DI_MAX_W-1:0]  free_disc;
      logic [FR_MAX_W-1:0]  victim;
      logic                 tbl_hit;
      logic [PID_MAX_W-1:0] tbl_hit_pid;
      logic                 sel_in_mem;
      logic [FR_MAX_W-1:0]  sel_frame;
      logic                 sel_on_disc;
      logic [DI_MAX_W-1:0]  sel_disc;
      logic [7:0]           pm_rdata;
      logic [7:0]           bs_rdata;
   } dpsm_stat_type;

endpackage

// ===== rtl/demand_paging_swap_manager.sv =====
// Top level of the demand-paging swap manager: controller plus datapath.
// Depends on dpsm_pkg, dpsm_controller, dpsm_datapath.
//
//   channel  ports                                         direction
//   req      req_valid/req_stall, kind, pid, vaddr, value  in
//   rsp      rsp_valid/rsp_stall, status, read_data,       out
//            phys_addr
//
// One item at a time.
// A table fault adds a frame fill, or a copy when the table comes back from disc.
// A page fault adds a copy when the page comes back from disc.
// An eviction adds a copy of the victim frame to disc, and for a data page an
// owner search through the tables of all PROCESSES.
// Synchronous reset empties all tables and frees all frames; memory is not
// cleared. A new item is taken while the last result waits on rsp_stall.
module demand_paging_swap_manager
   import dpsm_pkg::*;
#(
   parameter int MEM_BYTES   = 64,
   parameter int PAGE_BYTES  = 16,
   parameter int DISC_FRAMES = 20,
   parameter int PROCESSES   = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_kind,
   input  logic [1:0] req_pid,
   input  logic [5:0] req_vaddr,
   input  logic [7:0] req_value,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_read_data,
   output logic [5:0] rsp_phys_addr
);

   dpsm_cmd_type  cmd;
   dpsm_stat_type stat;

   dpsm_controller #(
      .MEM_BYTES  (MEM_BYTES),
      .PAGE_BYTES (PAGE_BYTES),
      .DISC_FRAMES(DISC_FRAMES),
      .PROCESSES  (PROCESSES)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_kind     (req_kind),
      .req_pid      (req_pid),
      .req_vaddr    (req_vaddr),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_read_data(rsp_read_data),
      .rsp_phys_addr(rsp_phys_addr),
      .cmd          (cmd),
      .stat         (stat)
   );

   dpsm_datapath #(
      .MEM_BYTES  (MEM_BYTES),
      .PAGE_BYTES (PAGE_BYTES),
      .DISC_FRAMES(DISC_FRAMES),
      .PROCESSES  (PROCESSES)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .cmd  (cmd),
      .stat (stat)
   );

endmodule

// ===== rtl/dpsm_datapath.sv =====
// Datapath: physical memory, backing store, page-table directory, free maps.
// Executes commands from dpsm_controller and reports status.
// Depends on dpsm_pkg.
module dpsm_datapath
   import dpsm_pkg::*;
#(
   parameter int MEM_BYTES   = 64,
   parameter int PAGE_BYTES  = 16,
   parameter int DISC_FRAMES = 20,
   parameter int PROCESSES   = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  dpsm_cmd_type  cmd,
   output dpsm_stat_type stat
);

   localparam int FRAMES   = MEM_BYTES / PAGE_BYTES;
   localparam int FR_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int PA_W     = $clog2(MEM_BYTES);
   localparam int BS_DEPTH = DISC_FRAMES * PAGE_BYTES;
   localparam int BA_W     = $clog2(BS_DEPTH);
   localparam int DI_W     = $clog2(DISC_FRAMES);
   localparam int PID_W    = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;

   logic [7:0] pm_mem [MEM_BYTES];
   logic [7:0] bs_mem [BS_DEPTH];
   logic [7:0] pm_rdata_ff;
   logic [7:0] bs_rdata_ff;

   logic [PROCESSES-1:0]   in_mem_ff;
   logic [PROCESSES-1:0]   on_disc_ff;
   logic [FR_W-1:0]        tframe_ff [PROCESSES];
   logic [DI_W-1:0]        tdisc_ff  [PROCESSES];
   logic [FRAMES-1:0]      ffree_ff;
   logic [DISC_FRAMES-1:0] dfree_ff;
   logic [FR_W-1:0]        victim_ff;

   logic [PID_W-1:0] psel;
   logic [FR_W-1:0]  fidx;
   logic [DI_W-1:0]  didx;

   assign psel = cmd.pid_sel[PID_W-1:0];
   assign fidx = cmd.frame_idx[FR_W-1:0];
   assign didx = cmd.disc_idx[DI_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.pm_we) pm_mem[cmd.pm_addr[PA_W-1:0]] <= cmd.pm_wdata;
      if (cmd.pm_re) pm_rdata_ff <= pm_mem[cmd.pm_addr[PA_W-1:0]];
      if (cmd.bs_we) bs_mem[cmd.bs_addr[BA_W-1:0]] <= cmd.bs_wdata;
      if (cmd.bs_re) bs_rdata_ff <= bs_mem[cmd.bs_addr[BA_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.tbl_load)  tframe_ff[psel] <= fidx;
      if (cmd.tbl_evict) tdisc_ff[psel]  <= didx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_mem_ff  <= '0;
         on_disc_ff <= '0;
         ffree_ff   <= '1;
         dfree_ff   <= '1;
         victim_ff  <= '0;
      end else begin
         if (cmd.tbl_load) begin
            in_mem_ff[psel]  <= 1'b1;
            on_disc_ff[psel] <= 1'b0;
         end
         if (cmd.tbl_evict) begin
            in_mem_ff[psel]  <= 1'b0;
            on_disc_ff[psel] <= 1'b1;
         end
         if (cmd.frame_we) ffree_ff[fidx] <= cmd.frame_free;
         if (cmd.disc_we)  dfree_ff[didx] <= cmd.disc_free;
         if (cmd.victim_adv) begin
            if (victim_ff == FR_W'(FRAMES - 1)) victim_ff <= '0;
            else victim_ff <= victim_ff + 1'b1;
         end
      end
   end

   always_comb begin
      logic             found;
      logic [FR_W-1:0]  ffirst;
      logic [DI_W-1:0]  dfirst;
      logic             hit;
      logic [PID_W-1:0] hit_pid;
      found   = 1'b0;
      ffirst  = '0;
      dfirst  = '0;
      hit     = 1'b0;
      hit_pid = '0;
      for (int i = FRAMES - 1; i >= 0; i--) begin
         if (ffree_ff[i]) begin
            found  = 1'b1;
            ffirst = FR_W'(i);
         end
      end
      for (int i = DISC_FRAMES - 1; i >= 0; i--) begin
         if (dfree_ff[i]) dfirst = DI_W'(i);
      end
      for (int p = 0; p < PROCESSES; p++) begin
         if (in_mem_ff[p] && tframe_ff[p] == victim_ff) begin
            hit     = 1'b1;
            hit_pid = PID_W'(p);
         end
      end
      stat.frame_found = found;
      stat.free_frame  = FR_MAX_W'(ffirst);
      stat.free_disc   = DI_MAX_W'(dfirst);
      stat.victim      = FR_MAX_W'(victim_ff);
      stat.tbl_hit     = hit;
      stat.tbl_hit_pid = PID_MAX_W'(hit_pid);
      stat.sel_in_mem  = in_mem_ff[psel];
      stat.sel_frame   = FR_MAX_W'(tframe_ff[psel]);
      stat.sel_on_disc = on_disc_ff[psel];
      stat.sel_disc    = DI_MAX_W'(tdisc_ff[psel]);
      stat.pm_rdata    = pm_rdata_ff;
      stat.bs_rdata    = bs_rdata_ff;
   end

endmodule

// ===== rtl/dpsm_controller.sv =====
// Controller: request sequencer for table load, eviction, page fault and access.
// Drives dpsm_datapath through command/status structs; holds the result register.
// Depends on dpsm_pkg.
module dpsm_controller
   import dpsm_pkg::*;
#(
   parameter int MEM_BYTES   = 64,
   parameter int PAGE_BYTES  = 16,
   parameter int DISC_FRAMES = 20,
   parameter int PROCESSES   = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [1:0]    req_kind,
   input  logic [1:0]    req_pid,
   input  logic [5:0]    req_vaddr,
   input  logic [7:0]    req_value,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [1:0]    rsp_status,
   output logic [7:0]    rsp_read_data,
   output logic [5:0]    rsp_phys_addr,
   output dpsm_cmd_type  cmd,
   input  dpsm_stat_type stat
);

   localparam int FRAMES = MEM_BYTES / PAGE_BYTES;
   localparam int FR_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int PB_W   = $clog2(PAGE_BYTES);
   localparam int EN_W   = PB_W - 2;
   localparam int PA_W   = $clog2(MEM_BYTES);
   localparam int BA_W   = $clog2(DISC_FRAMES * PAGE_BYTES);
   localparam int DI_W   = $clog2(DISC_FRAMES);
   localparam int PID_W  = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
   localparam int CNT_W  = PB_W + 1;

   typedef enum logic [4:0] {
      S_IDLE, S_ENS, S_ZERO, S_COPY, S_EV,
      S_SCAN_M, S_SCAN_MR, S_SCAN_MC, S_SCAN_D, S_SCAN_DR, S_SCAN_DC,
      S_EV_GO, S_EV_UPD, S_EV_WR,
      S_ENT_R0, S_ENT_R2, S_ENT_CHK, S_MAP_F, S_MAP_WR,
      S_ACC_R1, S_ACC_F, S_ACC_LD,
      S_BR_ENS, S_BR_FREE, S_BR_R3, S_BR_CHK, S_BR_WR,
      S_DONE
   } state_type;

   function automatic logic [PA_W-1:0] pm_at(logic [FR_W-1:0] fr, logic [PB_W-1:0] o);
      return PA_W'({fr, o});
   endfunction

   function automatic logic [BA_W-1:0] bs_at(logic [DI_W-1:0] d, logic [PB_W-1:0] o);
      return BA_W'({d, o});
   endfunction

   function automatic logic [PB_W-1:0] ent(logic [EN_W-1:0] j, logic [1:0] b);
      return {j, b};
   endfunction

   // entry disc byte reduced modulo DISC_FRAMES by binary-weighted compare and subtract
   function automatic logic [DI_W-1:0] disc_mod(logic [7:0] b);
      logic [15:0] r;
      r = 16'(b);
      for (int k = 7; k >= 0; k--) begin
         if (r >= 16'(DISC_FRAMES << k)) r = r - 16'(DISC_FRAMES << k);
      end
      return r[DI_W-1:0];
   endfunction

   state_type        state_ff, state_in, cp_ret_ff, cp_ret_in;
   logic [1:0]       kind_ff, kind_in;
   logic [PID_W-1:0] pid_ff, pid_in, sp_ff, sp_in, tblp_ff, tblp_in;
   logic [EN_W-1:0]  page_ff, page_in, sj_ff, sj_in;
   logic [PB_W-1:0]  off_ff, off_in;
   logic [7:0]       val_ff, val_in, perm_ff, perm_in, e0_ff, e0_in, b2_ff, b2_in;
   logic [FR_W-1:0]  f_ff, f_in, v_ff, v_in;
   logic [DI_W-1:0]  d_ff, d_in;
   logic             tbl_ff, tbl_in, own_ff, own_in, own_pm_ff, own_pm_in;
   logic [PA_W-1:0]  own_pa_ff, own_pa_in;
   logic [BA_W-1:0]  own_ba_ff, own_ba_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             cp_in_ff, cp_in_in;
   logic             ens_br_ff, ens_br_in, ev_br_ff, ev_br_in, br_map_ff, br_map_in;
   logic [1:0]       res_st_ff, res_st_in;
   logic [7:0]       res_data_ff, res_data_in;
   logic [PA_W-1:0]  res_pa_ff, res_pa_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_st_ff, rsp_st_in;
   logic [7:0]       rsp_data_ff, rsp_data_in;
   logic [5:0]       rsp_pa_ff, rsp_pa_in;

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_st_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_phys_addr = rsp_pa_ff;

   always_comb begin
      logic [4:0]      pid_wide;
      logic [7:0]      va8;
      logic [FR_W-1:0] tf;
      logic [FR_W-1:0] fr;
      logic [PA_W-1:0] pa;
      logic            finish_ev;
      logic            last_j;
      logic            last_p;
      logic [7:0]      wbyte;
      logic [DI_W-1:0] dmod;

      state_in = state_ff;   cp_ret_in = cp_ret_ff;   kind_in = kind_ff;
      pid_in = pid_ff;       sp_in = sp_ff;           tblp_in = tblp_ff;
      page_in = page_ff;     sj_in = sj_ff;           off_in = off_ff;
      val_in = val_ff;       perm_in = perm_ff;       e0_in = e0_ff;
      b2_in = b2_ff;         f_in = f_ff;             v_in = v_ff;
      d_in = d_ff;           tbl_in = tbl_ff;         own_in = own_ff;
      own_pm_in = own_pm_ff; own_pa_in = own_pa_ff;   own_ba_in = own_ba_ff;
      cnt_in = cnt_ff;       cp_in_in = cp_in_ff;     ens_br_in = ens_br_ff;
      ev_br_in = ev_br_ff;   br_map_in = br_map_ff;   res_st_in = res_st_ff;
      res_data_in = res_data_ff;                      res_pa_in = res_pa_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_st_in = rsp_st_ff; rsp_data_in = rsp_data_ff; rsp_pa_in = rsp_pa_ff;

      cmd = '0;
      cmd.pid_sel = PID_MAX_W'(pid_ff);
      pid_wide  = 5'(req_pid);
      va8       = {2'b00, req_vaddr};
      tf        = stat.sel_frame[FR_W-1:0];
      fr        = stat.pm_rdata[FR_W-1:0];
      pa        = pm_at(fr, off_ff);
      finish_ev = 1'b0;
      last_j    = (sj_ff == EN_W'(PAGE_BYTES / 4 - 1));
      last_p    = (sp_ff == PID_W'(PROCESSES - 1));
      wbyte     = '0;
      dmod      = disc_mod(stat.pm_rdata);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               for (int i = 0; i < 3; i++) begin
                  if (pid_wide >= 5'(PROCESSES)) pid_wide = pid_wide - 5'(PROCESSES);
               end
               kind_in     = req_kind;
               pid_in      = PID_W'(pid_wide);
               page_in     = EN_W'(va8 >> PB_W);
               off_in      = PB_W'(va8);
               val_in      = req_value;
               res_st_in   = STAT_DONE;
               res_data_in = '0;
               res_pa_in   = '0;
               ens_br_in   = 1'b0;
               if (req_kind > KIND_LOAD) state_in = S_DONE;
               else state_in = S_ENS;
            end
         end
         S_ENS: begin
            if (stat.sel_in_mem) begin
               state_in = ens_br_ff ? S_BR_FREE : S_ENT_R0;
            end else if (stat.frame_found) begin
               f_in           = stat.free_frame[FR_W-1:0];
               cmd.frame_we   = 1'b1;
               cmd.frame_free = 1'b0;
               cmd.frame_idx  = stat.free_frame;
               cmd.tbl_load   = 1'b1;
               cnt_in         = '0;
               if (stat.sel_on_disc) begin
                  d_in          = stat.sel_disc[DI_W-1:0];
                  cmd.disc_we   = 1'b1;
                  cmd.disc_free = 1'b1;
                  cmd.disc_idx  = stat.sel_disc;
                  cp_in_in      = 1'b1;
                  cp_ret_in     = S_ENS;
                  state_in      = S_COPY;
               end else begin
                  state_in = S_ZERO;
               end
            end else begin
               ev_br_in = 1'b0;
               state_in = S_EV;
            end
         end
         S_ZERO: begin
            cmd.pm_we    = 1'b1;
            cmd.pm_addr  = PA_MAX_W'(pm_at(f_ff, cnt_ff[PB_W-1:0]));
            cmd.pm_wdata = '0;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(PAGE_BYTES - 1)) begin
               cnt_in   = '0;
               state_in = S_ENS;
            end
         end
         S_COPY: begin
            if (cnt_ff != CNT_W'(PAGE_BYTES)) begin
               if (cp_in_ff) begin
                  cmd.bs_re   = 1'b1;
                  cmd.bs_addr = BA_MAX_W'(bs_at(d_ff, cnt_ff[PB_W-1:0]));
               end else begin
                  cmd.pm_re   = 1'b1;
                  cmd.pm_addr = PA_MAX_W'(pm_at(v_ff, cnt_ff[PB_W-1:0]));
               end
            end
            if (cnt_ff != '0) begin
               if (cp_in_ff) begin
                  cmd.pm_we    = 1'b1;
                  cmd.pm_addr  = PA_MAX_W'(pm_at(f_ff, PB_W'(cnt_ff - 1'b1)));
                  cmd.pm_wdata = stat.bs_rdata;
               end else begin
                  cmd.bs_we    = 1'b1;
                  cmd.bs_addr  = BA_MAX_W'(bs_at(d_ff, PB_W'(cnt_ff - 1'b1)));
                  cmd.bs_wdata = stat.pm_rdata;
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(PAGE_BYTES)) begin
               cnt_in   = '0;
               state_in = cp_ret_ff;
            end
         end
         S_EV: begin
            v_in    = stat.victim[FR_W-1:0];
            d_in    = stat.free_disc[DI_W-1:0];
            tbl_in  = stat.tbl_hit;
            tblp_in = stat.tbl_hit_pid[PID_W-1:0];
            own_in  = 1'b0;
            sp_in   = '0;
            sj_in   = '0;
            state_in = stat.tbl_hit ? S_EV_GO : S_SCAN_M;
         end
         S_SCAN_M: begin
            cmd.pid_sel = PID_MAX_W'(sp_ff);
            if (!stat.sel_in_mem) begin
               sj_in = '0;
               if (last_p) begin
                  sp_in    = '0;
                  state_in = own_ff ? S_EV_GO : S_SCAN_D;
               end else begin
                  sp_in = sp_ff + 1'b1;
               end
            end else begin
               cmd.pm_re   = 1'b1;
               cmd.pm_addr = PA_MAX_W'(pm_at(tf, ent(sj_ff, BYTE_MARK)));
               state_in    = S_SCAN_MR;
            end
         end
         S_SCAN_MR: begin
            cmd.pid_sel = PID_MAX_W'(sp_ff);
            b2_in       = stat.pm_rdata;
            cmd.pm_re   = 1'b1;
            cmd.pm_addr = PA_MAX_W'(pm_at(tf, ent(sj_ff, BYTE_FRAME)));
            state_in    = S_SCAN_MC;
         end
         S_SCAN_MC: begin
            cmd.pid_sel = PID_MAX_W'(sp_ff);
            if (b2_ff == MARK_PRESENT && stat.pm_rdata == 8'(v_ff)) begin
               own_in    = 1'b1;
               own_pm_in = 1'b1;
               own_pa_in = pm_at(tf, ent(sj_ff, BYTE_PERM));
            end
            state_in = S_SCAN_M;
            if (last_j) begin
               sj_in = '0;
               if (last_p) begin
                  sp_in    = '0;
                  state_in = own_in ? S_EV_GO : S_SCAN_D;
               end else begin
                  sp_in = sp_ff + 1'b1;
               end
            end else begin
               sj_in = sj_ff + 1'b1;
            end
         end
         S_SCAN_D: begin
            cmd.pid_sel = PID_MAX_W'(sp_ff);
            if (!stat.sel_on_disc) begin
               sj_in = '0;
               if (last_p) state_in = S_EV_GO;
               else sp_in = sp_ff + 1'b1;
            end else begin
               cmd.bs_re   = 1'b1;
               cmd.bs_addr = BA_MAX_W'(bs_at(stat.sel_disc[DI_W-1:0],
                                             ent(sj_ff, BYTE_MARK)));
               state_in    = S_SCAN_DR;
            end
         end
         S_SCAN_DR: begin
            cmd.pid_sel = PID_MAX_W'(sp_ff);
            b2_in       = stat.bs_rdata;
            cmd.bs_re   = 1'b1;
            cmd.bs_addr = BA_MAX_W'(bs_at(stat.sel_disc[DI_W-1:0],
                                          ent(sj_ff, BYTE_FRAME)));
            state_in    = S_SCAN_DC;
         end
         S_SCAN_DC: begin
            cmd.pid_sel = PID_MAX_W'(sp_ff);
            if (b2_ff == MARK_PRESENT && stat.bs_rdata == 8'(v_ff)) begin
               own_in    = 1'b1;
               own_pm_in = 1'b0;
               own_ba_in = bs_at(stat.sel_disc[DI_W-1:0], ent(sj_ff, BYTE_PERM));
            end
            state_in = S_SCAN_D;
            if (last_j) begin
               sj_in = '0;
               if (last_p) state_in = S_EV_GO;
               else sp_in = sp_ff + 1'b1;
            end else begin
               sj_in = sj_ff + 1'b1;
            end
         end
         S_EV_GO: begin
            if (!tbl_ff && !own_ff) begin
               res_st_in   = STAT_NO_OWNER;
               res_data_in = '0;
               res_pa_in   = '0;
               state_in    = S_DONE;
            end else begin
               cmd.disc_we   = 1'b1;
               cmd.disc_free = 1'b0;
               cmd.disc_idx  = DI_MAX_W'(d_ff);
               cnt_in        = '0;
               cp_in_in      = 1'b0;
               cp_ret_in     = S_EV_UPD;
               state_in      = S_COPY;
            end
         end
         S_EV_UPD: begin
            cnt_in = '0;
            if (tbl_ff) begin
               cmd.pid_sel   = PID_MAX_W'(tblp_ff);
               cmd.tbl_evict = 1'b1;
               cmd.disc_idx  = DI_MAX_W'(d_ff);
               finish_ev     = 1'b1;
            end else begin
               state_in = S_EV_WR;
            end
         end
         S_EV_WR: begin
            priority if (cnt_ff == CNT_W'(0)) wbyte = NONE_BYTE;
            else if (cnt_ff == CNT_W'(1))     wbyte = MARK_DISC;
            else                              wbyte = 8'(d_ff);
            if (own_pm_ff) begin
               cmd.pm_we    = 1'b1;
               cmd.pm_addr  = PA_MAX_W'(own_pa_ff + PA_W'(cnt_ff + 1'b1));
               cmd.pm_wdata = wbyte;
            end else begin
               cmd.bs_we    = 1'b1;
               cmd.bs_addr  = BA_MAX_W'(own_ba_ff + BA_W'(cnt_ff + 1'b1));
               cmd.bs_wdata = wbyte;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(2)) begin
               cnt_in    = '0;
               finish_ev = 1'b1;
            end
         end
         S_ENT_R0: begin
            cmd.pm_re   = 1'b1;
            cmd.pm_addr = PA_MAX_W'(pm_at(tf, ent(page_ff, BYTE_PERM)));
            state_in    = S_ENT_R2;
         end
         S_ENT_R2: begin
            e0_in       = stat.pm_rdata;
            cmd.pm_re   = 1'b1;
            cmd.pm_addr = PA_MAX_W'(pm_at(tf, ent(page_ff, BYTE_MARK)));
            state_in    = S_ENT_CHK;
         end
         S_ENT_CHK: begin
            if (kind_ff == KIND_MAP) begin
               if (stat.pm_rdata != MARK_PRESENT) begin
                  perm_in   = val_ff;
                  br_map_in = 1'b1;
                  state_in  = S_BR_ENS;
               end else begin
                  cmd.pm_re   = 1'b1;
                  cmd.pm_addr = PA_MAX_W'(pm_at(tf, ent(page_ff, BYTE_FRAME)));
                  state_in    = S_MAP_F;
               end
            end else if (kind_ff == KIND_STORE && e0_ff == '0) begin
               res_st_in = STAT_NOT_WRITABLE;
               state_in  = S_DONE;
            end else if (stat.pm_rdata != MARK_PRESENT) begin
               perm_in   = (kind_ff == KIND_STORE) ? 8'd1 : e0_ff;
               br_map_in = 1'b0;
               state_in  = S_BR_ENS;
            end else begin
               state_in = S_ACC_R1;
            end
         end
         S_MAP_F: begin
            f_in     = fr;
            state_in = S_MAP_WR;
         end
         S_MAP_WR: begin
            cmd.pm_we    = 1'b1;
            cmd.pm_addr  = PA_MAX_W'(pm_at(tf, ent(page_ff, BYTE_PERM)));
            cmd.pm_wdata = val_ff;
            res_st_in    = STAT_DONE;
            res_pa_in    = pm_at(f_ff, '0);
            state_in     = S_DONE;
         end
         S_ACC_R1: begin
            cmd.pm_re   = 1'b1;
            cmd.pm_addr = PA_MAX_W'(pm_at(tf, ent(page_ff, BYTE_FRAME)));
            state_in    = S_ACC_F;
         end
         S_ACC_F: begin
            res_pa_in = pa;
            res_st_in = STAT_DONE;
            if (kind_ff == KIND_STORE) begin
               cmd.pm_we    = 1'b1;
               cmd.pm_addr  = PA_MAX_W'(pa);
               cmd.pm_wdata = val_ff;
               state_in     = S_DONE;
            end else begin
               cmd.pm_re   = 1'b1;
               cmd.pm_addr = PA_MAX_W'(pa);
               state_in    = S_ACC_LD;
            end
         end
         S_ACC_LD: begin
            res_data_in = stat.pm_rdata;
            state_in    = S_DONE;
         end
         S_BR_ENS: begin
            ens_br_in = 1'b1;
            state_in  = S_ENS;
         end
         S_BR_FREE: begin
            if (stat.frame_found) begin
               f_in           = stat.free_frame[FR_W-1:0];
               cmd.frame_we   = 1'b1;
               cmd.frame_free = 1'b0;
               cmd.frame_idx  = stat.free_frame;
               cmd.pm_re      = 1'b1;
               cmd.pm_addr    = PA_MAX_W'(pm_at(tf, ent(page_ff, BYTE_MARK)));
               state_in       = S_BR_R3;
            end else begin
               ev_br_in = 1'b1;
               state_in = S_EV;
            end
         end
         S_BR_R3: begin
            b2_in       = stat.pm_rdata;
            cmd.pm_re   = 1'b1;
            cmd.pm_addr = PA_MAX_W'(pm_at(tf, ent(page_ff, BYTE_DISC)));
            state_in    = S_BR_CHK;
         end
         S_BR_CHK: begin
            cnt_in = '0;
            if (b2_ff == MARK_DISC) begin
               d_in          = dmod;
               cmd.disc_we   = 1'b1;
               cmd.disc_free = 1'b1;
               cmd.disc_idx  = DI_MAX_W'(dmod);
               cp_in_in      = 1'b1;
               cp_ret_in     = S_BR_WR;
               state_in      = S_COPY;
            end else begin
               state_in = S_BR_WR;
            end
         end
         S_BR_WR: begin
            priority if (cnt_ff == CNT_W'(0)) wbyte = perm_ff;
            else if (cnt_ff == CNT_W'(1))     wbyte = 8'(f_ff);
            else if (cnt_ff == CNT_W'(2))     wbyte = MARK_PRESENT;
            else                              wbyte = NONE_BYTE;
            cmd.pm_we    = 1'b1;
            cmd.pm_addr  = PA_MAX_W'(pm_at(tf, ent(page_ff, cnt_ff[1:0])));
            cmd.pm_wdata = wbyte;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(3)) begin
               cnt_in   = '0;
               state_in = br_map_ff ? S_MAP_WR : S_ACC_R1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_st_in    = res_st_ff;
               rsp_data_in  = res_data_ff;
               rsp_pa_in    = 6'(res_pa_ff);
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (finish_ev) begin
         cmd.frame_we   = 1'b1;
         cmd.frame_free = 1'b1;
         cmd.frame_idx  = FR_MAX_W'(v_ff);
         cmd.victim_adv = 1'b1;
         state_in       = ev_br_ff ? S_BR_ENS : S_ENS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cp_ret_ff    <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         ens_br_ff    <= 1'b0;
         ev_br_ff     <= 1'b0;
         br_map_ff    <= 1'b0;
         cp_in_ff     <= 1'b0;
         cnt_ff       <= '0;
         tbl_ff       <= 1'b0;
         own_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cp_ret_ff    <= cp_ret_in;
         rsp_valid_ff <= rsp_valid_in;
         ens_br_ff    <= ens_br_in;
         ev_br_ff     <= ev_br_in;
         br_map_ff    <= br_map_in;
         cp_in_ff     <= cp_in_in;
         cnt_ff       <= cnt_in;
         tbl_ff       <= tbl_in;
         own_ff       <= own_in;
      end
      kind_ff     <= kind_in;
      pid_ff      <= pid_in;
      sp_ff       <= sp_in;
      tblp_ff     <= tblp_in;
      page_ff     <= page_in;
      sj_ff       <= sj_in;
      off_ff      <= off_in;
      val_ff      <= val_in;
      perm_ff     <= perm_in;
      e0_ff       <= e0_in;
      b2_ff       <= b2_in;
      f_ff        <= f_in;
      v_ff        <= v_in;
      d_ff        <= d_in;
      own_pm_ff   <= own_pm_in;
      own_pa_ff   <= own_pa_in;
      own_ba_ff   <= own_ba_in;
      res_st_ff   <= res_st_in;
      res_data_ff <= res_data_in;
      res_pa_ff   <= res_pa_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_data_ff <= rsp_data_in;
      rsp_pa_ff   <= rsp_pa_in;
   end

endmodule
